>>> sv/smm_pkg.sv
package smm_pkg;

   // Default store dimensions.
   localparam int MAX_ROWS_DEF = 16;
   localparam int MAX_COLS_DEF = 16;

   // Field widths.
   localparam int IDX_W      = 4;
   localparam int SIZE_W     = 5;
   localparam int VAL_W      = 32;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;

   // Datapath widths: dot product, scaled sum and the shared multiplier.
   localparam int DOT_W  = 64;
   localparam int ACC_W  = 96;
   localparam int MUL_W  = 33;
   localparam int PROD_W = 66;

   // Entries in the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Register reset values.
   localparam logic [SIZE_W-1:0] ROWS_RESET  = 5'd16;
   localparam logic [SIZE_W-1:0] COLS_RESET  = 5'd16;
   localparam logic [VAL_W-1:0]  ALPHA_RESET = 32'h0001_0000;
   localparam logic [VAL_W-1:0]  BETA_RESET  = 32'h0000_0000;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_A = 2'd0,
      OP_LOAD_B = 2'd1,
      OP_LOAD_C = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_USED  = 2'd0,
      CSR_COLS_USED  = 2'd1,
      CSR_ALPHA_GAIN = 2'd2,
      CSR_BETA_GAIN  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_LOAD_A,
      KIND_LOAD_B,
      KIND_LOAD_C,
      KIND_READ,
      KIND_READ_ERR,
      KIND_DROP
   } item_kind_type;

   typedef struct packed {
      item_kind_type           kind;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic [VAL_W-1:0]        value;
   } entry_type;

   // Effective sizes (already clamped) and gains.
   typedef struct packed {
      logic [SIZE_W-1:0] rows;
      logic [SIZE_W-1:0] cols;
      logic [VAL_W-1:0]  alpha;
      logic [VAL_W-1:0]  beta;
   } cfg_type;

   typedef enum logic [1:0] {
      PK_DOT,
      PK_ALPHA_LO,
      PK_ALPHA_HI,
      PK_BETA
   } prod_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DOT,
      ST_DRAIN,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MUL_C,
      ST_SUM,
      ST_DONE
   } back_state_type;

endpackage

>>> sv/smm_ram.sv
module smm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/smm_front.sv
module smm_front #(
   parameter int MAX_ROWS = smm_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = smm_pkg::MAX_COLS_DEF
) (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [smm_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [smm_pkg::REQ_USER_W-1:0]    req_tuser,
   input  smm_pkg::cfg_type                  cfg,
   input  logic                              q_ready,
   output logic                              q_push,
   output smm_pkg::entry_type                q_entry
);

   localparam int IDX_W = smm_pkg::IDX_W;
   localparam int VAL_W = smm_pkg::VAL_W;

   logic [IDX_W-1:0]       row;
   logic [IDX_W-1:0]       col;
   logic [VAL_W-1:0]       value;
   logic                   row_in_store;
   logic                   col_in_store;
   smm_pkg::item_kind_type kind;

   // Unpack the request and decide what the back end has to do with it.
   always_comb begin
      row          = req_tdata[IDX_W-1:0];
      col          = req_tdata[2*IDX_W-1:IDX_W];
      value        = req_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
      row_in_store = int'(row) < MAX_ROWS;
      col_in_store = int'(col) < MAX_COLS;
      unique case (smm_pkg::op_type'(req_tuser))
         smm_pkg::OP_LOAD_A: begin
            // Only the lower triangle of A is kept.
            kind = (row_in_store && (col <= row)) ? smm_pkg::KIND_LOAD_A
                                                  : smm_pkg::KIND_DROP;
         end
         smm_pkg::OP_LOAD_B: begin
            kind = (row_in_store && col_in_store) ? smm_pkg::KIND_LOAD_B
                                                  : smm_pkg::KIND_DROP;
         end
         smm_pkg::OP_LOAD_C: begin
            kind = (row_in_store && col_in_store) ? smm_pkg::KIND_LOAD_C
                                                  : smm_pkg::KIND_DROP;
         end
         smm_pkg::OP_READ: begin
            kind = (({1'b0, row} >= cfg.rows) || ({1'b0, col} >= cfg.cols))
                   ? smm_pkg::KIND_READ_ERR : smm_pkg::KIND_READ;
         end
      endcase
   end

   // Ignored loads are consumed here and never reach the queue.
   assign req_tready    = q_ready;
   assign q_push        = req_tvalid && q_ready && (kind != smm_pkg::KIND_DROP);
   assign q_entry.kind  = kind;
   assign q_entry.row   = row;
   assign q_entry.col   = col;
   assign q_entry.value = value;

endmodule

>>> sv/smm_queue.sv
module smm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  smm_pkg::entry_type push_entry,
   output logic               ready,
   input  logic               pop,
   output logic               valid,
   output smm_pkg::entry_type head
);

   localparam int DEPTH = smm_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   smm_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign ready = count_ff != CNT_W'(DEPTH);
   assign valid = count_ff != '0;
   assign head  = slots_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> sv/smm_back.sv
module smm_back #(
   parameter int MAX_ROWS = smm_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = smm_pkg::MAX_COLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  smm_pkg::cfg_type               cfg,
   input  logic                           q_valid,
   input  smm_pkg::entry_type             q_entry,
   output logic                           q_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [smm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [smm_pkg::RSP_USER_W-1:0] rsp_tuser
);

   localparam int A_DEPTH  = MAX_ROWS * MAX_ROWS;
   localparam int BC_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int A_AW     = $clog2(A_DEPTH);
   localparam int BC_AW    = $clog2(BC_DEPTH);
   localparam int IDX_W    = smm_pkg::IDX_W;
   localparam int SIZE_W   = smm_pkg::SIZE_W;
   localparam int VAL_W    = smm_pkg::VAL_W;
   localparam int DOT_W    = smm_pkg::DOT_W;
   localparam int ACC_W    = smm_pkg::ACC_W;
   localparam int MUL_W    = smm_pkg::MUL_W;
   localparam int PROD_W   = smm_pkg::PROD_W;
   localparam int FRAC_W   = 16;

   smm_pkg::back_state_type state_ff;
   smm_pkg::back_state_type state_in;
   logic [SIZE_W-1:0]       k_ff;
   logic [SIZE_W-1:0]       k_in;
   logic [IDX_W-1:0]        job_row_ff;
   logic [IDX_W-1:0]        job_row_in;
   logic [IDX_W-1:0]        job_col_ff;
   logic [IDX_W-1:0]        job_col_in;
   logic                    term_valid_ff;
   logic                    term_valid_in;
   logic                    prod_valid_ff;
   logic                    prod_valid_in;
   smm_pkg::prod_kind_type  prod_kind_ff;
   smm_pkg::prod_kind_type  prod_kind_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic [DOT_W-1:0]        dot_ff;
   logic [DOT_W-1:0]        dot_in;
   logic [ACC_W-1:0]        x_ff;
   logic [ACC_W-1:0]        x_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [VAL_W-1:0]        rsp_value_ff;
   logic [VAL_W-1:0]        rsp_value_in;
   logic [IDX_W-1:0]        rsp_row_ff;
   logic [IDX_W-1:0]        rsp_row_in;
   logic [IDX_W-1:0]        rsp_col_ff;
   logic [IDX_W-1:0]        rsp_col_in;
   logic                    rsp_sat_ff;
   logic                    rsp_sat_in;
   logic                    rsp_err_ff;
   logic                    rsp_err_in;

   logic                    job_start;
   logic                    out_load;
   logic                    out_err;
   logic                    out_free;
   logic                    a_we;
   logic                    b_we;
   logic                    c_we;
   logic [A_AW-1:0]         a_wr_addr;
   logic [BC_AW-1:0]        bc_wr_addr;
   logic [SIZE_W-1:0]       sym_hi;
   logic [SIZE_W-1:0]       sym_lo;
   logic [A_AW-1:0]         a_rd_addr;
   logic [BC_AW-1:0]        b_rd_addr;
   logic [BC_AW-1:0]        c_rd_addr;
   logic [VAL_W-1:0]        a_rd;
   logic [VAL_W-1:0]        b_rd;
   logic [VAL_W-1:0]        c_rd;
   logic signed [MUL_W-1:0] mul_a;
   logic signed [MUL_W-1:0] mul_b;
   logic                    fits;
   logic [VAL_W-1:0]        sat_value;

   // Store addressing: loads write at the queue head, the dot walk reads
   // the symmetric element S[row][k] from the lower triangle.
   assign a_wr_addr  = A_AW'(int'(q_entry.row) * MAX_ROWS + int'(q_entry.col));
   assign bc_wr_addr = BC_AW'(int'(q_entry.row) * MAX_COLS + int'(q_entry.col));
   assign sym_hi     = ({1'b0, job_row_ff} >= k_ff) ? {1'b0, job_row_ff} : k_ff;
   assign sym_lo     = ({1'b0, job_row_ff} >= k_ff) ? k_ff : {1'b0, job_row_ff};
   assign a_rd_addr  = A_AW'(int'(sym_hi) * MAX_ROWS + int'(sym_lo));
   assign b_rd_addr  = BC_AW'(int'(k_ff) * MAX_COLS + int'(job_col_ff));
   assign c_rd_addr  = BC_AW'(int'(job_row_ff) * MAX_COLS + int'(job_col_ff));

   smm_ram #(
      .WIDTH (VAL_W),
      .DEPTH (A_DEPTH)
   ) u_a_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_wr_addr),
      .wr_data (q_entry.value),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd)
   );

   smm_ram #(
      .WIDTH (VAL_W),
      .DEPTH (BC_DEPTH)
   ) u_b_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (bc_wr_addr),
      .wr_data (q_entry.value),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd)
   );

   smm_ram #(
      .WIDTH (VAL_W),
      .DEPTH (BC_DEPTH)
   ) u_c_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (bc_wr_addr),
      .wr_data (q_entry.value),
      .rd_addr (c_rd_addr),
      .rd_data (c_rd)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Sequencer: next state, queue pops, store writes and result loads.
   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      job_row_in = job_row_ff;
      job_col_in = job_col_ff;
      q_pop      = 1'b0;
      a_we       = 1'b0;
      b_we       = 1'b0;
      c_we       = 1'b0;
      job_start  = 1'b0;
      out_load   = 1'b0;
      out_err    = 1'b0;
      unique case (state_ff)
         smm_pkg::ST_IDLE: begin
            if (q_valid) begin
               unique case (q_entry.kind)
                  smm_pkg::KIND_LOAD_A: begin
                     q_pop = 1'b1;
                     a_we  = 1'b1;
                  end
                  smm_pkg::KIND_LOAD_B: begin
                     q_pop = 1'b1;
                     b_we  = 1'b1;
                  end
                  smm_pkg::KIND_LOAD_C: begin
                     q_pop = 1'b1;
                     c_we  = 1'b1;
                  end
                  smm_pkg::KIND_READ: begin
                     q_pop      = 1'b1;
                     job_start  = 1'b1;
                     k_in       = '0;
                     job_row_in = q_entry.row;
                     job_col_in = q_entry.col;
                     state_in   = smm_pkg::ST_DOT;
                  end
                  smm_pkg::KIND_READ_ERR: begin
                     if (out_free) begin
                        q_pop    = 1'b1;
                        out_load = 1'b1;
                        out_err  = 1'b1;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         smm_pkg::ST_DOT: begin
            k_in = k_ff + 1'b1;
            if (k_ff == cfg.rows - 1'b1) begin
               state_in = smm_pkg::ST_DRAIN;
            end
         end
         smm_pkg::ST_DRAIN: begin
            if (!term_valid_ff && !prod_valid_ff) begin
               state_in = smm_pkg::ST_MUL_LO;
            end
         end
         smm_pkg::ST_MUL_LO: begin
            state_in = smm_pkg::ST_MUL_HI;
         end
         smm_pkg::ST_MUL_HI: begin
            state_in = smm_pkg::ST_MUL_C;
         end
         smm_pkg::ST_MUL_C: begin
            state_in = smm_pkg::ST_SUM;
         end
         smm_pkg::ST_SUM: begin
            state_in = smm_pkg::ST_DONE;
         end
         smm_pkg::ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = smm_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // Shared multiplier operands: dot terms from the stores, then the
   // alpha scaling of the low and high dot halves and the beta term.
   always_comb begin
      mul_a         = '0;
      mul_b         = '0;
      prod_valid_in = 1'b0;
      prod_kind_in  = smm_pkg::PK_DOT;
      if (term_valid_ff) begin
         mul_a         = {a_rd[VAL_W-1], a_rd};
         mul_b         = {b_rd[VAL_W-1], b_rd};
         prod_valid_in = 1'b1;
      end else begin
         unique case (state_ff)
            smm_pkg::ST_MUL_LO: begin
               mul_a         = {cfg.alpha[VAL_W-1], cfg.alpha};
               mul_b         = {1'b0, dot_ff[VAL_W-1:0]};
               prod_valid_in = 1'b1;
               prod_kind_in  = smm_pkg::PK_ALPHA_LO;
            end
            smm_pkg::ST_MUL_HI: begin
               mul_a         = {cfg.alpha[VAL_W-1], cfg.alpha};
               mul_b         = {dot_ff[DOT_W-1], dot_ff[DOT_W-1:VAL_W]};
               prod_valid_in = 1'b1;
               prod_kind_in  = smm_pkg::PK_ALPHA_HI;
            end
            smm_pkg::ST_MUL_C: begin
               mul_a         = {cfg.beta[VAL_W-1], cfg.beta};
               mul_b         = {c_rd[VAL_W-1], c_rd};
               prod_valid_in = 1'b1;
               prod_kind_in  = smm_pkg::PK_BETA;
            end
            default: begin
               prod_valid_in = 1'b0;
            end
         endcase
      end
   end

   assign prod_in       = mul_a * mul_b;
   assign term_valid_in = state_ff == smm_pkg::ST_DOT;

   // Accumulation behind the product register. Dot terms are floored to
   // Q16.16 before summing; the scaled sum is kept exact at 2^-32.
   always_comb begin
      dot_in = dot_ff;
      x_in   = x_ff;
      if (job_start) begin
         dot_in = '0;
         x_in   = '0;
      end else if (prod_valid_ff) begin
         unique case (prod_kind_ff)
            smm_pkg::PK_DOT: begin
               dot_in = dot_ff + {{FRAC_W{prod_ff[DOT_W-1]}}, prod_ff[DOT_W-1:FRAC_W]};
            end
            smm_pkg::PK_ALPHA_LO: begin
               x_in = x_ff + {{(ACC_W-DOT_W-1){prod_ff[DOT_W]}}, prod_ff[DOT_W:0]};
            end
            smm_pkg::PK_ALPHA_HI: begin
               x_in = x_ff + {prod_ff[DOT_W-1:0], {VAL_W{1'b0}}};
            end
            smm_pkg::PK_BETA: begin
               x_in = x_ff + {{(ACC_W-DOT_W){prod_ff[DOT_W-1]}}, prod_ff[DOT_W-1:0]};
            end
         endcase
      end
   end

   // Final shift by 16 and clamp to the signed 32-bit range.
   always_comb begin
      fits = (&x_ff[ACC_W-1:VAL_W+FRAC_W-1]) || !(|x_ff[ACC_W-1:VAL_W+FRAC_W-1]);
      if (fits) begin
         sat_value = x_ff[VAL_W+FRAC_W-1:FRAC_W];
      end else begin
         sat_value = x_ff[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                   : {1'b0, {(VAL_W-1){1'b1}}};
      end
      rsp_value_in = out_err ? '0 : sat_value;
      rsp_row_in   = out_err ? q_entry.row : job_row_ff;
      rsp_col_in   = out_err ? q_entry.col : job_col_ff;
      rsp_sat_in   = !out_err && !fits;
      rsp_err_in   = out_err;
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= smm_pkg::ST_IDLE;
         term_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         term_valid_ff <= term_valid_in;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      job_row_ff   <= job_row_in;
      job_col_ff   <= job_col_in;
      prod_ff      <= prod_in;
      prod_kind_ff <= prod_kind_in;
      dot_ff       <= dot_in;
      x_ff         <= x_in;
      if (out_load) begin
         rsp_value_ff <= rsp_value_in;
         rsp_row_ff   <= rsp_row_in;
         rsp_col_ff   <= rsp_col_in;
         rsp_sat_ff   <= rsp_sat_in;
         rsp_err_ff   <= rsp_err_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_col_ff, rsp_row_ff, rsp_value_ff};
   assign rsp_tuser  = {rsp_err_ff, rsp_sat_ff};

`ifndef SYNTHESIS
   // An out-of-range read carries a zero value and no saturation.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> (rsp_value_ff == '0) && !rsp_sat_ff)
      else $error("range error result with nonzero value or saturation");

   // Scaling starts only once every dot term has been summed.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == smm_pkg::ST_MUL_LO |-> !term_valid_ff && !prod_valid_ff)
      else $error("dot product pipeline not drained before scaling");

   // Popping an in-range read starts the row walk in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      q_pop && (q_entry.kind == smm_pkg::KIND_READ) |=> state_ff == smm_pkg::ST_DOT)
      else $error("read popped without starting the dot walk");
`endif

endmodule

>>> sv/symmetric_matrix_multiply.sv
// Loads of A, B and C0 pass through the queue and are written into their store when
// the back end pops them; loads stream at one per cycle while the back end is idle.
// An in-range read occupies the back end until its result is loaded into the output
// register: one shared 33x33 multiplier walks the rows one per cycle, then does three
// scaling products.
// Reset is synchronous and active high; it clears control and registers, not stores.
module symmetric_matrix_multiply #(
   parameter int MAX_ROWS = smm_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = smm_pkg::MAX_COLS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // Bits from the lowest: row_index[3:0], col_index[7:4], in_value[39:8].
   input  logic [smm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Bits from the lowest: op[1:0].
   input  logic [smm_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // Bits from the lowest: out_value[31:0], out_row[35:32], out_col[39:36].
   output logic [smm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // Bits from the lowest: saturated[0], range_error[1].
   output logic [smm_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input  logic                            csr_we,
   input  logic [smm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [smm_pkg::VAL_W-1:0]       csr_wdata
);

   localparam int SIZE_W = smm_pkg::SIZE_W;
   localparam int VAL_W  = smm_pkg::VAL_W;

   logic [SIZE_W-1:0]  rows_used_ff;
   logic [SIZE_W-1:0]  rows_used_in;
   logic [SIZE_W-1:0]  cols_used_ff;
   logic [SIZE_W-1:0]  cols_used_in;
   logic [VAL_W-1:0]   alpha_ff;
   logic [VAL_W-1:0]   alpha_in;
   logic [VAL_W-1:0]   beta_ff;
   logic [VAL_W-1:0]   beta_in;
   smm_pkg::cfg_type   cfg;
   logic               q_ready;
   logic               q_push;
   smm_pkg::entry_type push_entry;
   logic               q_valid;
   logic               q_pop;
   smm_pkg::entry_type head_entry;

   // Register writes.
   always_comb begin
      rows_used_in = rows_used_ff;
      cols_used_in = cols_used_ff;
      alpha_in     = alpha_ff;
      beta_in      = beta_ff;
      if (csr_we) begin
         unique case (smm_pkg::csr_index_type'(csr_index))
            smm_pkg::CSR_ROWS_USED:  rows_used_in = csr_wdata[SIZE_W-1:0];
            smm_pkg::CSR_COLS_USED:  cols_used_in = csr_wdata[SIZE_W-1:0];
            smm_pkg::CSR_ALPHA_GAIN: alpha_in     = csr_wdata;
            smm_pkg::CSR_BETA_GAIN:  beta_in      = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_used_ff <= smm_pkg::ROWS_RESET;
         cols_used_ff <= smm_pkg::COLS_RESET;
         alpha_ff     <= smm_pkg::ALPHA_RESET;
         beta_ff      <= smm_pkg::BETA_RESET;
      end else begin
         rows_used_ff <= rows_used_in;
         cols_used_ff <= cols_used_in;
         alpha_ff     <= alpha_in;
         beta_ff      <= beta_in;
      end
   end

   // Sizes of zero act as one, sizes beyond the stores act as the maximum.
   always_comb begin
      if (rows_used_ff == '0) begin
         cfg.rows = SIZE_W'(1);
      end else if (int'(rows_used_ff) > MAX_ROWS) begin
         cfg.rows = SIZE_W'(MAX_ROWS);
      end else begin
         cfg.rows = rows_used_ff;
      end
      if (cols_used_ff == '0) begin
         cfg.cols = SIZE_W'(1);
      end else if (int'(cols_used_ff) > MAX_COLS) begin
         cfg.cols = SIZE_W'(MAX_COLS);
      end else begin
         cfg.cols = cols_used_ff;
      end
      cfg.alpha = alpha_ff;
      cfg.beta  = beta_ff;
   end

   smm_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   smm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .ready      (q_ready),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (head_entry)
   );

   smm_back #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_entry    (head_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> tb/symmetric_matrix_multiply_test.sv
`timescale 1ns / 100ps

module symmetric_matrix_multiply_test;
   import smm_pkg::*;

   // One result element as it leaves the block.
   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             saturated;
      logic             range_error;
   } element_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // Bits from the lowest: row_index[3:0], col_index[7:4], in_value[39:8].
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   // Bits from the lowest: op[1:0].
   logic [REQ_USER_W-1:0]  req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // Bits from the lowest: out_value[31:0], out_row[35:32], out_col[39:36].
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   // Bits from the lowest: saturated[0], range_error[1].
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [VAL_W-1:0]       csr_wdata = '0;

   // Shadow copy of the stores and registers.
   logic [VAL_W-1:0]  a_matrix [MAX_ROWS_DEF][MAX_ROWS_DEF];
   logic [VAL_W-1:0]  b_matrix [MAX_ROWS_DEF][MAX_COLS_DEF];
   logic [VAL_W-1:0]  c_matrix [MAX_ROWS_DEF][MAX_COLS_DEF];
   logic [SIZE_W-1:0] rows_setting = ROWS_RESET;
   logic [SIZE_W-1:0] cols_setting = COLS_RESET;
   logic [VAL_W-1:0]  alpha_setting = ALPHA_RESET;
   logic [VAL_W-1:0]  beta_setting = BETA_RESET;

   element_type pending_elements[$];
   int          error_count = 0;
   bit          req_idle = 1'b1;
   bit          rsp_idle = 1'b1;

   symmetric_matrix_multiply DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // A size register of zero acts as one, and anything above the store acts as its size.
   function automatic int used_size(logic [SIZE_W-1:0] setting, int limit);
      if (setting == 0) return 1;
      if (setting > limit) return limit;
      return int'(setting);
   endfunction

   // Mostly short signed values so that sums stay in range, now and then an extreme.
   function automatic logic [VAL_W-1:0] random_value();
      int                      width;
      logic signed [VAL_W-1:0] raw;
      if ($urandom_range(0, 15) == 0) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      width = $urandom_range(1, 32);
      raw = $urandom;
      raw = raw << (32 - width);
      return raw >>> (32 - width);
   endfunction

   // Computes one element of beta*C0 + alpha*S*B with the block's rounding and clamping.
   function automatic element_type predict_element(logic [IDX_W-1:0] row,
                                                   logic [IDX_W-1:0] col);
      element_type              result;
      int                       m;
      int                       n;
      longint                   dot;
      longint                   partial;
      logic [VAL_W-1:0]         s_value;
      logic signed [127:0]      alpha_wide;
      logic signed [127:0]      dot_wide;
      logic signed [127:0]      beta_wide;
      logic signed [127:0]      c_wide;
      logic signed [127:0]      scaled;
      m = used_size(rows_setting, MAX_ROWS_DEF);
      n = used_size(cols_setting, MAX_COLS_DEF);
      result.row = row;
      result.col = col;
      result.value = '0;
      result.saturated = 1'b0;
      result.range_error = 1'b0;
      if (row >= m || col >= n) begin
         result.range_error = 1'b1;
         return result;
      end
      dot = 0;
      for (int k = 0; k < m; k++) begin
         // Only the lower triangle is stored; mirror it for the upper one.
         s_value = (row >= k) ? a_matrix[row][k] : a_matrix[k][row];
         partial = longint'($signed(s_value)) * longint'($signed(b_matrix[k][col]));
         dot += partial >>> 16;
      end
      alpha_wide = 128'($signed(alpha_setting));
      dot_wide = 128'(dot);
      beta_wide = 128'($signed(beta_setting));
      c_wide = 128'($signed(c_matrix[row][col]));
      scaled = (alpha_wide * dot_wide + beta_wide * c_wide) >>> 16;
      if (&scaled[127:31] || ~|scaled[127:31]) begin
         result.value = scaled[31:0];
      end else begin
         result.saturated = 1'b1;
         result.value = scaled[127] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return result;
   endfunction

   task automatic report_mismatch(string message);
      $display("ERROR at %0t ns: %s", $time, message);
      error_count++;
   endtask

   // Updates the shadow state for one accepted request and records any result it causes.
   task automatic apply_request(op_type op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                logic [VAL_W-1:0] value);
      case (op)
         OP_LOAD_A: begin
            if (col <= row) a_matrix[row][col] = value;
         end
         OP_LOAD_B: b_matrix[row][col] = value;
         OP_LOAD_C: c_matrix[row][col] = value;
         default: pending_elements.push_back(predict_element(row, col));
      endcase
   endtask

   // Offers one request, after a random gap while req_idle is set, and waits for the handshake.
   task automatic send_request(op_type op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                               logic [VAL_W-1:0] value);
      int gap;
      gap = req_idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {value, col, row};
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
      apply_request(op, row, col, value);
   endtask

   // Waits until every result is back and the back end has finished any trailing loads.
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (pending_elements.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type index, logic [VAL_W-1:0] data);
      wait_for_idle();
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_ROWS_USED:  rows_setting = data[SIZE_W-1:0];
         CSR_COLS_USED:  cols_setting = data[SIZE_W-1:0];
         CSR_ALPHA_GAIN: alpha_setting = data;
         default:        beta_setting = data;
      endcase
   endtask

   task automatic configure(logic [SIZE_W-1:0] rows, logic [SIZE_W-1:0] cols,
                            logic [VAL_W-1:0] alpha, logic [VAL_W-1:0] beta);
      write_register(CSR_ROWS_USED, VAL_W'(rows));
      write_register(CSR_COLS_USED, VAL_W'(cols));
      write_register(CSR_ALPHA_GAIN, alpha);
      write_register(CSR_BETA_GAIN, beta);
   endtask

   // Every entry that a read can reach is written once up front, so no read ever touches an unwritten one.
   task automatic test_fill_stores();
      for (int r = 0; r < MAX_ROWS_DEF; r++) begin
         for (int c = 0; c < MAX_COLS_DEF; c++) begin
            if (c <= r) send_request(OP_LOAD_A, IDX_W'(r), IDX_W'(c), random_value());
            send_request(OP_LOAD_B, IDX_W'(r), IDX_W'(c), random_value());
            send_request(OP_LOAD_C, IDX_W'(r), IDX_W'(c), random_value());
         end
      end
   endtask

   // Extreme element values at the corners under the reset configuration.
   task automatic test_extreme_values();
      send_request(OP_LOAD_A, 0, 0, 32'h7FFF_FFFF);
      send_request(OP_LOAD_B, 0, 0, 32'h7FFF_FFFF);
      send_request(OP_READ, 0, 0, 32'h0000_0000);
      send_request(OP_LOAD_A, 15, 0, 32'h8000_0000);
      send_request(OP_READ, 15, 0, 32'hFFFF_FFFF);
      send_request(OP_READ, 15, 15, 32'h0000_0000);
   endtask

   // A load of A above the diagonal must leave the mirrored entry alone.
   task automatic test_upper_triangle_load();
      send_request(OP_LOAD_A, 3, 12, 32'h1234_5678);
      send_request(OP_READ, 3, 5, 32'h0000_0000);
      send_request(OP_READ, 12, 5, 32'h0000_0000);
   endtask

   // Reads at and past the edge of the used size; those past it answer zero with the error flag.
   task automatic test_range_error();
      configure(3, 2, ALPHA_RESET, BETA_RESET);
      send_request(OP_READ, 2, 1, 32'h0000_0000);
      send_request(OP_READ, 3, 0, 32'h0000_0000);
      send_request(OP_READ, 0, 2, 32'h0000_0000);
      send_request(OP_READ, 15, 15, 32'h0000_0000);
   endtask

   // Size registers of zero and above the store size are clamped.
   task automatic test_size_clamp();
      configure(0, 0, ALPHA_RESET, BETA_RESET);
      send_request(OP_READ, 0, 0, 32'h0000_0000);
      send_request(OP_READ, 1, 0, 32'h0000_0000);
      send_request(OP_READ, 0, 1, 32'h0000_0000);
      configure(31, 17, ALPHA_RESET, BETA_RESET);
      send_request(OP_READ, 15, 15, 32'h0000_0000);
      send_request(OP_READ, 15, 0, 32'h0000_0000);
   endtask

   // Extreme gains, including a product term switched off.
   task automatic test_extreme_gains();
      configure(16, 16, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_READ, 5, 5, 32'h0000_0000);
      configure(16, 16, 32'h0000_0000, 32'h0001_0000);
      send_request(OP_READ, 3, 4, 32'h0000_0000);
      configure(16, 16, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(OP_READ, 9, 2, 32'h0000_0000);
   endtask

   // A mix of loads and reads; most reads land inside the used size.
   task automatic run_random_phase(int count);
      int               pick;
      int               m;
      int               n;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      m = used_size(rows_setting, MAX_ROWS_DEF);
      n = used_size(cols_setting, MAX_COLS_DEF);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 9);
         row = IDX_W'($urandom_range(0, 15));
         col = IDX_W'($urandom_range(0, 15));
         if (pick < 4) begin
            if ($urandom_range(0, 4) != 0) begin
               row = IDX_W'($urandom_range(0, m - 1));
               col = IDX_W'($urandom_range(0, n - 1));
            end
            send_request(OP_READ, row, col, $urandom);
         end else if (pick < 6) begin
            send_request(OP_LOAD_A, row, col, random_value());
         end else if (pick < 8) begin
            send_request(OP_LOAD_B, row, col, random_value());
         end else begin
            send_request(OP_LOAD_C, row, col, random_value());
         end
      end
   endtask

   task automatic test_random_traffic();
      configure(16, 16, ALPHA_RESET, BETA_RESET);
      run_random_phase(30);
      // Back to back on both sides.
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      configure(SIZE_W'($urandom_range(1, 16)), SIZE_W'($urandom_range(1, 16)),
                random_value(), random_value());
      run_random_phase(25);
      for (int phase = 0; phase < 3; phase++) begin
         req_idle = 1'($urandom_range(0, 1));
         rsp_idle = 1'($urandom_range(0, 1));
         configure(SIZE_W'($urandom_range(0, 31)), SIZE_W'($urandom_range(0, 31)),
                   random_value(), random_value());
         run_random_phase(25);
      end
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      configure(1, 16, 32'h8000_0000, 32'h7FFF_FFFF);
      run_random_phase(15);
      configure(16, 1, random_value(), random_value());
      run_random_phase(15);
   endtask

   // Accepts results, with random stalls while rsp_idle is set, and compares them with the oldest prediction.
   initial begin : result_checker
      int          stall;
      element_type seen;
      element_type wanted;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = rsp_idle ? $urandom_range(0, 8) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         seen.value = rsp_tdata[31:0];
         seen.row = rsp_tdata[35:32];
         seen.col = rsp_tdata[39:36];
         seen.saturated = rsp_tuser[0];
         seen.range_error = rsp_tuser[1];
         if (pending_elements.size() == 0) begin
            report_mismatch($sformatf("unexpected result for row %0d col %0d",
                                      seen.row, seen.col));
         end else begin
            wanted = pending_elements.pop_front();
            if (seen.value !== wanted.value)
               report_mismatch($sformatf("C[%0d][%0d] value %h, expected %h",
                                         wanted.row, wanted.col, seen.value, wanted.value));
            if (seen.row !== wanted.row)
               report_mismatch($sformatf("row %0d, expected %0d", seen.row, wanted.row));
            if (seen.col !== wanted.col)
               report_mismatch($sformatf("column %0d, expected %0d", seen.col, wanted.col));
            if (seen.saturated !== wanted.saturated)
               report_mismatch($sformatf("C[%0d][%0d] saturated flag %b, expected %b",
                                         wanted.row, wanted.col, seen.saturated,
                                         wanted.saturated));
            if (seen.range_error !== wanted.range_error)
               report_mismatch($sformatf("C[%0d][%0d] range error flag %b, expected %b",
                                         wanted.row, wanted.col, seen.range_error,
                                         wanted.range_error));
         end
      end
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : test_sequence
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_stores();
      test_extreme_values();
      test_upper_triangle_load();
      test_range_error();
      test_size_clamp();
      test_extreme_gains();
      test_random_traffic();
      wait_for_idle();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
